[rtl/srs_pkg.sv]
package srs_pkg;

   // field widths
   localparam int POS_W = 38;
   localparam int VEL_W = 32;
   localparam int TOF_W = 40;
   localparam int RNG_W = 38;
   localparam int THR_W = 40;
   localparam int ITER_W = 4;
   localparam int LS_W = 29;
   localparam int ER_W = 36;

   // configuration port
   localparam int CSR_AW = 6;
   localparam int CSR_DW = 64;
   localparam logic [2:0] REG_SMALL_ANGLE = 3'd0;
   localparam logic [2:0] REG_THRESHOLD   = 3'd1;
   localparam logic [2:0] REG_MAX_ITER    = 3'd2;
   localparam logic [2:0] REG_LIGHT_SPEED = 3'd3;
   localparam logic [2:0] REG_EARTH_RATE  = 3'd4;

   // shared multiplier
   localparam int MUL_W = 64;
   localparam int PROD_W = 128;
   localparam int MRES_W = 80;

   // root / divide unit
   localparam int SD_SRC_W = 82;
   localparam int SD_ROOT_W = 41;
   localparam int SD_REM_W = 44;
   localparam int SD_RES_W = 42;
   localparam int SD_NUM_W = 68;

   typedef enum logic [2:0] {
      SH_NONE,
      SH_DIV6,
      SH_40,
      SH_48,
      SH_49
   } mul_shift_type;

   typedef struct packed {
      logic          start;
      mul_shift_type shift;
   } mul_cmd_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } sd_cmd_type;

endpackage

[rtl/srs_req_if.sv]
interface srs_req_if;
   import srs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] rx_x;
   logic signed [POS_W-1:0] rx_y;
   logic signed [POS_W-1:0] rx_z;
   logic signed [POS_W-1:0] sat_x;
   logic signed [POS_W-1:0] sat_y;
   logic signed [POS_W-1:0] sat_z;
   logic signed [VEL_W-1:0] sat_vx;
   logic signed [VEL_W-1:0] sat_vy;
   logic signed [VEL_W-1:0] sat_vz;
   logic [TOF_W-1:0]        seed_tof;

   modport source (output valid, rx_x, rx_y, rx_z, sat_x, sat_y, sat_z,
                   sat_vx, sat_vy, sat_vz, seed_tof, input ready);
   modport sink (input valid, rx_x, rx_y, rx_z, sat_x, sat_y, sat_z,
                 sat_vx, sat_vy, sat_vz, seed_tof, output ready);
endinterface

[rtl/srs_rsp_if.sv]
interface srs_rsp_if;
   import srs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [RNG_W-1:0]        geo_range;
   logic signed [POS_W-1:0] rot_x;
   logic signed [POS_W-1:0] rot_y;
   logic signed [POS_W-1:0] rot_z;
   logic signed [VEL_W-1:0] rot_vx;
   logic signed [VEL_W-1:0] rot_vy;
   logic signed [VEL_W-1:0] rot_vz;

   modport source (output valid, geo_range, rot_x, rot_y, rot_z, rot_vx, rot_vy, rot_vz,
                   input ready);
   modport sink (input valid, geo_range, rot_x, rot_y, rot_z, rot_vx, rot_vy, rot_vz,
                 output ready);
endinterface

[rtl/srs_mul.sv]
module srs_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  srs_pkg::mul_cmd_type        cmd,
   input  logic [srs_pkg::MUL_W-1:0]   op_a,
   input  logic [srs_pkg::MUL_W-1:0]   op_b,
   output logic                        done,
   output logic [srs_pkg::MRES_W-1:0]  result
);
   import srs_pkg::*;

   logic [MUL_W-1:0]  a_ff;
   logic [MUL_W-1:0]  b_ff;
   mul_shift_type     shift_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [63:0]       pp_ff;
   logic [1:0]        pp_sel_ff;
   logic [2:0]        step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [31:0]       part_a;
   logic [31:0]       part_b;
   logic [PROD_W-1:0] pp_shifted;
   logic [PROD_W-1:0] rnd;

   // 32x32 partial products, one per cycle, each accumulated in the cycle after it is formed
   assign part_a = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign part_b = step_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      case (pp_sel_ff) inside
         2'd0:       pp_shifted = {64'b0, pp_ff};
         2'd1, 2'd2: pp_shifted = {32'b0, pp_ff, 32'b0};
         default:    pp_shifted = {pp_ff, 64'b0};
      endcase
   end

   // half an output lsb preloaded for round to nearest on the 40-, 48- and 49-bit shifts
   always_comb begin
      rnd = '0;
      case (cmd.shift)
         SH_40:   rnd[39] = 1'b1;
         SH_48:   rnd[47] = 1'b1;
         SH_49:   rnd[48] = 1'b1;
         default: rnd = '0;
      endcase
   end

   always_comb begin
      case (shift_ff)
         SH_DIV6: result = acc_ff[99:20];
         SH_40:   result = acc_ff[119:40];
         SH_48:   result = acc_ff[127:48];
         SH_49:   result = {1'b0, acc_ff[127:49]};
         default: result = acc_ff[79:0];
      endcase
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff     <= op_a;
         b_ff     <= op_b;
         shift_ff <= cmd.shift;
         acc_ff   <= rnd;
      end else if (busy_ff) begin
         pp_ff     <= {32'b0, part_a} * {32'b0, part_b};
         pp_sel_ff <= step_ff[1:0];
         if (step_ff != 3'd0) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
   end

endmodule

[rtl/srs_sqdiv.sv]
module srs_sqdiv (
   input  logic                          clock,
   input  logic                          reset,
   input  srs_pkg::sd_cmd_type           cmd,
   input  logic [srs_pkg::MRES_W-1:0]    radicand,
   input  logic [srs_pkg::SD_NUM_W-1:0]  dividend,
   input  logic [srs_pkg::LS_W-1:0]      divisor,
   output logic                          done,
   output logic [srs_pkg::SD_RES_W-1:0]  result
);
   import srs_pkg::*;

   logic [SD_REM_W-1:0]  rem_ff;
   logic [SD_ROOT_W-1:0] root_ff;
   logic [SD_SRC_W-1:0]  src_ff;
   logic [LS_W-1:0]      div_ff;
   logic [5:0]           cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 sqrt_ff;
   logic                 ovf_ff;
   logic [SD_REM_W-1:0]  rem_sh;
   logic [SD_REM_W-1:0]  trial;
   logic [SD_REM_W:0]    diff;
   logic                 take;

   // one shared shift-subtract step: root digit pairs or quotient bits
   assign rem_sh = sqrt_ff ? {rem_ff[SD_REM_W-3:0], src_ff[SD_SRC_W-1 -: 2]}
                           : {rem_ff[SD_REM_W-2:0], src_ff[SD_SRC_W-1]};
   assign trial  = sqrt_ff ? {1'b0, root_ff, 2'b01}
                           : {{(SD_REM_W-LS_W){1'b0}}, div_ff};
   assign diff   = {1'b0, rem_sh} - {1'b0, trial};
   assign take   = !diff[SD_REM_W];

   always_comb begin
      if (sqrt_ff) begin
         if (rem_ff > {3'b0, root_ff}) begin
            result = {1'b0, root_ff} + 42'd1;
         end else begin
            result = {1'b0, root_ff};
         end
      end else if (ovf_ff) begin
         result = {2'b0, {TOF_W{1'b1}}};
      end else begin
         result = {2'b0, root_ff[TOF_W-1:0]};
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.is_sqrt ? 6'd41 : 6'd40;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sqrt_ff <= cmd.is_sqrt;
         div_ff  <= divisor;
         root_ff <= '0;
         if (cmd.is_sqrt) begin
            rem_ff <= '0;
            src_ff <= {2'b0, radicand};
            ovf_ff <= 1'b0;
         end else begin
            // top part already at least the divisor: quotient does not fit
            rem_ff <= {16'b0, dividend[SD_NUM_W-1:TOF_W]};
            src_ff <= {dividend[TOF_W-1:0], 42'b0};
            ovf_ff <= {1'b0, dividend[SD_NUM_W-1:TOF_W]} >= divisor;
         end
      end else if (busy_ff) begin
         rem_ff  <= take ? diff[SD_REM_W-1:0] : rem_sh;
         root_ff <= {root_ff[SD_ROOT_W-2:0], take};
         src_ff  <= sqrt_ff ? {src_ff[SD_SRC_W-3:0], 2'b0} : {src_ff[SD_SRC_W-2:0], 1'b0};
      end
   end

endmodule

[rtl/sagnac_range_solver.sv]
// channel | dir | handshake          | word
// req     | in  | valid/ready        | receiver, satellite pos/vel, seed tof
// rsp     | out | valid/ready        | range, rotated pos/vel
// csr     | in  | psel/penable/pwrite| 5 registers at 8*i, 64-bit data
//
// one item at a time; a loop evaluation runs 16 products on the shared 32x32 multiplier,
// the 41-step root, the 40-step divide and the check; the closing evaluation skips the
// divide and the check and then loads the result word
// small-angle mode skips 4 products per evaluation
// a finished word sits in the output register while the next item is taken
// reset is synchronous and restores the register defaults; no clearing pass
module sagnac_range_solver (
   input  logic                        clock,
   input  logic                        reset,
   srs_req_if.sink                     req_chan,
   srs_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [srs_pkg::CSR_AW-1:0]  paddr,
   input  logic [srs_pkg::CSR_DW-1:0]  pwdata,
   output logic [srs_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import srs_pkg::*;

   localparam logic [48:0] ONE48 = 49'h1_0000_0000_0000;
   localparam logic [17:0] DIV6_RECIP = 18'd174763;
   localparam logic signed [40:0] POS_MAX = 41'sd137438953471;
   localparam logic signed [40:0] POS_MIN = -41'sd137438953472;
   localparam logic signed [40:0] VEL_MAX = 41'sd2147483647;
   localparam logic signed [40:0] VEL_MIN = -41'sd2147483648;

   typedef enum logic [3:0] {
      S_IDLE, S_ANG, S_T2, S_HALF, S_T3, S_DIV6, S_ROT, S_DIST, S_SQRT, S_DIV,
      S_CHECK, S_DONE
   } state_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [40:0] v);
      return (v > POS_MAX) ? POS_MAX[POS_W-1:0] :
             ((v < POS_MIN) ? POS_MIN[POS_W-1:0] : v[POS_W-1:0]);
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [40:0] v);
      return (v > VEL_MAX) ? VEL_MAX[VEL_W-1:0] :
             ((v < VEL_MIN) ? VEL_MIN[VEL_W-1:0] : v[VEL_W-1:0]);
   endfunction

   // configuration
   logic              small_angle_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [ITER_W-1:0] max_iter_ff;
   logic [LS_W-1:0]   ls_ff;
   logic [ER_W-1:0]   er_ff;

   // working state
   state_type               state_ff;
   logic signed [POS_W-1:0] rx_ff [3];
   logic signed [POS_W-1:0] sp_ff [3];
   logic signed [VEL_W-1:0] sv_ff [3];
   logic [TOF_W-1:0]        tof_ff;
   logic [TOF_W-1:0]        tof_new_ff;
   logic [ITER_W-1:0]       iter_ff;
   logic                    last_pass_ff;
   logic                    issued_ff;
   logic [ER_W-1:0]         ang_ff;
   logic [24:0]             t2_ff;
   logic [12:0]             t3_ff;
   logic [48:0]             cos_ff;
   logic [ER_W-1:0]         sin_ff;
   logic [2:0]              cnt_ff;
   logic signed [40:0]      pair_acc_ff;
   logic signed [POS_W-1:0] rp_x_ff;
   logic signed [POS_W-1:0] rp_y_ff;
   logic signed [VEL_W-1:0] rv_x_ff;
   logic signed [VEL_W-1:0] rv_y_ff;
   logic [MRES_W-1:0]       sum_ff;
   logic [RNG_W-1:0]        range_ff;

   // result word
   logic                    rsp_valid_ff;
   logic [RNG_W-1:0]        out_range_ff;
   logic signed [POS_W-1:0] out_x_ff;
   logic signed [POS_W-1:0] out_y_ff;
   logic signed [POS_W-1:0] out_z_ff;
   logic signed [VEL_W-1:0] out_vx_ff;
   logic signed [VEL_W-1:0] out_vy_ff;
   logic signed [VEL_W-1:0] out_vz_ff;

   // shared units
   mul_cmd_type         mul_cmd_ff;
   logic [MUL_W-1:0]    mul_a_ff;
   logic [MUL_W-1:0]    mul_b_ff;
   logic                mul_done;
   logic [MRES_W-1:0]   mul_res;
   sd_cmd_type          sd_cmd_ff;
   logic                sd_done;
   logic [SD_RES_W-1:0] sd_res;

   // combinational helpers
   logic [LS_W-1:0]         c_eff;
   logic [SD_NUM_W-1:0]     dividend;
   logic                    use_y;
   logic                    use_s;
   logic                    rot_neg;
   logic signed [POS_W-1:0] pos_v;
   logic signed [VEL_W-1:0] vel_v;
   logic signed [39:0]      rot_v;
   logic [39:0]             rot_mag;
   logic [48:0]             rot_k;
   logic signed [40:0]      term_mag;
   logic signed [40:0]      term;
   logic signed [40:0]      pair_sum;
   logic signed [POS_W-1:0] dist_rp;
   logic signed [POS_W:0]   d_raw;
   logic [POS_W:0]          d_mag;
   logic [TOF_W-1:0]        delta;
   logic                    req_take;
   logic                    csr_wr;

   srs_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd_ff),
      .op_a   (mul_a_ff),
      .op_b   (mul_b_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   srs_sqdiv u_sqdiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (sd_cmd_ff),
      .radicand (sum_ff),
      .dividend (dividend),
      .divisor  (c_eff),
      .done     (sd_done),
      .result   (sd_res)
   );

   assign c_eff = (ls_ff == '0) ? LS_W'(1) : ls_ff;
   // range * 2^30 + c/2, divided later for a rounded tof
   assign dividend = {range_ff, 30'b0} + {40'b0, c_eff[LS_W-1:1]};

   // rotation product order: x*c, y*s, y*c, -x*s; position first, then velocity
   assign use_y   = cnt_ff[0] ^ cnt_ff[1];
   assign use_s   = cnt_ff[0];
   assign rot_neg = cnt_ff[0] & cnt_ff[1];
   assign pos_v   = use_y ? sp_ff[1] : sp_ff[0];
   assign vel_v   = use_y ? sv_ff[1] : sv_ff[0];
   assign rot_v   = cnt_ff[2] ? {{8{vel_v[VEL_W-1]}}, vel_v} : {{2{pos_v[POS_W-1]}}, pos_v};
   assign rot_mag = rot_v[39] ? 40'(-rot_v) : 40'(rot_v);
   assign rot_k   = use_s ? {13'b0, sin_ff} : cos_ff;

   // rounded magnitude takes the sign of the operand, flipped for the -x*s product
   assign term_mag = $signed({1'b0, mul_res[39:0]});
   assign term     = (rot_v[39] ^ rot_neg) ? -term_mag : term_mag;
   assign pair_sum = (cnt_ff[0] ? pair_acc_ff : 41'sd0) + term;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    dist_rp = rp_x_ff;
         2'd1:    dist_rp = rp_y_ff;
         default: dist_rp = sp_ff[2];
      endcase
   end

   assign d_raw = {rx_ff[cnt_ff[1:0]][POS_W-1], rx_ff[cnt_ff[1:0]]}
                - {dist_rp[POS_W-1], dist_rp};
   assign d_mag = d_raw[POS_W] ? (POS_W+1)'(-d_raw) : (POS_W+1)'(d_raw);

   assign delta = (tof_new_ff >= tof_ff) ? (tof_new_ff - tof_ff) : (tof_ff - tof_new_ff);

   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.geo_range = out_range_ff;
   assign rsp_chan.rot_x     = out_x_ff;
   assign rsp_chan.rot_y     = out_y_ff;
   assign rsp_chan.rot_z     = out_z_ff;
   assign rsp_chan.rot_vx    = out_vx_ff;
   assign rsp_chan.rot_vy    = out_vy_ff;
   assign rsp_chan.rot_vz    = out_vz_ff;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr[5:3])
         REG_SMALL_ANGLE: prdata = {63'b0, small_angle_ff};
         REG_THRESHOLD:   prdata = {24'b0, thr_ff};
         REG_MAX_ITER:    prdata = {60'b0, max_iter_ff};
         REG_LIGHT_SPEED: prdata = {35'b0, ls_ff};
         REG_EARTH_RATE:  prdata = {28'b0, er_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_angle_ff <= 1'b0;
         thr_ff         <= 40'd1;
         max_iter_ff    <= 4'd5;
         ls_ff          <= 29'd299792458;
         er_ff          <= 36'd20525479411;
      end else if (csr_wr) begin
         unique case (paddr[5:3])
            REG_SMALL_ANGLE: small_angle_ff <= pwdata[0];
            REG_THRESHOLD:   thr_ff         <= pwdata[THR_W-1:0];
            REG_MAX_ITER:    max_iter_ff    <= pwdata[ITER_W-1:0];
            REG_LIGHT_SPEED: ls_ff          <= pwdata[LS_W-1:0];
            REG_EARTH_RATE:  er_ff          <= pwdata[ER_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         issued_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         mul_cmd_ff      <= '{start: 1'b0, shift: SH_NONE};
         sd_cmd_ff       <= '0;
      end else begin
         // start pulses last one cycle; a unit is only started while issued_ff is low
         if (issued_ff) begin
            mul_cmd_ff.start <= 1'b0;
            sd_cmd_ff.start  <= 1'b0;
         end
         if (rsp_chan.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  rx_ff[0]     <= req_chan.rx_x;
                  rx_ff[1]     <= req_chan.rx_y;
                  rx_ff[2]     <= req_chan.rx_z;
                  sp_ff[0]     <= req_chan.sat_x;
                  sp_ff[1]     <= req_chan.sat_y;
                  sp_ff[2]     <= req_chan.sat_z;
                  sv_ff[0]     <= req_chan.sat_vx;
                  sv_ff[1]     <= req_chan.sat_vy;
                  sv_ff[2]     <= req_chan.sat_vz;
                  tof_ff       <= req_chan.seed_tof;
                  iter_ff      <= '0;
                  last_pass_ff <= 1'b0;
                  issued_ff    <= 1'b0;
                  state_ff     <= S_ANG;
               end
            end
            S_ANG: begin
               if (!issued_ff) begin
                  mul_cmd_ff <= '{start: 1'b1, shift: SH_40};
                  mul_a_ff   <= {28'b0, er_ff};
                  mul_b_ff   <= {24'b0, tof_ff};
                  issued_ff  <= 1'b1;
               end else if (mul_done) begin
                  issued_ff <= 1'b0;
                  ang_ff    <= mul_res[ER_W-1:0];
                  if (small_angle_ff) begin
                     cos_ff   <= ONE48;
                     sin_ff   <= mul_res[ER_W-1:0];
                     cnt_ff   <= '0;
                     state_ff <= S_ROT;
                  end else begin
                     state_ff <= S_T2;
                  end
               end
            end
            S_T2, S_HALF: begin
               if (!issued_ff) begin
                  mul_cmd_ff <= '{start: 1'b1, shift: (state_ff == S_T2) ? SH_48 : SH_49};
                  mul_a_ff   <= {28'b0, ang_ff};
                  mul_b_ff   <= {28'b0, ang_ff};
                  issued_ff  <= 1'b1;
               end else if (mul_done) begin
                  issued_ff <= 1'b0;
                  if (state_ff == S_T2) begin
                     t2_ff    <= mul_res[24:0];
                     state_ff <= S_HALF;
                  end else begin
                     cos_ff   <= ONE48 - mul_res[48:0];
                     state_ff <= S_T3;
                  end
               end
            end
            S_T3: begin
               if (!issued_ff) begin
                  mul_cmd_ff <= '{start: 1'b1, shift: SH_48};
                  mul_a_ff   <= {39'b0, t2_ff};
                  mul_b_ff   <= {28'b0, ang_ff};
                  issued_ff  <= 1'b1;
               end else if (mul_done) begin
                  issued_ff <= 1'b0;
                  t3_ff     <= mul_res[12:0];
                  state_ff  <= S_DIV6;
               end
            end
            S_DIV6: begin
               // (t3 + 3) / 6 by reciprocal, exact for these magnitudes
               if (!issued_ff) begin
                  mul_cmd_ff <= '{start: 1'b1, shift: SH_DIV6};
                  mul_a_ff   <= {50'b0, {1'b0, t3_ff} + 14'd3};
                  mul_b_ff   <= {46'b0, DIV6_RECIP};
                  issued_ff  <= 1'b1;
               end else if (mul_done) begin
                  issued_ff <= 1'b0;
                  sin_ff    <= ang_ff - mul_res[ER_W-1:0];
                  cnt_ff    <= '0;
                  state_ff  <= S_ROT;
               end
            end
            S_ROT: begin
               if (!issued_ff) begin
                  mul_cmd_ff <= '{start: 1'b1, shift: SH_48};
                  mul_a_ff   <= {24'b0, rot_mag};
                  mul_b_ff   <= {15'b0, rot_k};
                  issued_ff  <= 1'b1;
               end else if (mul_done) begin
                  issued_ff <= 1'b0;
                  if (!cnt_ff[0]) begin
                     pair_acc_ff <= pair_sum;
                  end else begin
                     case (cnt_ff[2:1])
                        2'd0:    rp_x_ff <= sat_pos(pair_sum);
                        2'd1:    rp_y_ff <= sat_pos(pair_sum);
                        2'd2:    rv_x_ff <= sat_vel(pair_sum);
                        default: rv_y_ff <= sat_vel(pair_sum);
                     endcase
                  end
                  if (cnt_ff == 3'd7) begin
                     cnt_ff   <= '0;
                     sum_ff   <= '0;
                     state_ff <= S_DIST;
                  end else begin
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end
            end
            S_DIST: begin
               if (!issued_ff) begin
                  mul_cmd_ff <= '{start: 1'b1, shift: SH_NONE};
                  mul_a_ff   <= {25'b0, d_mag};
                  mul_b_ff   <= {25'b0, d_mag};
                  issued_ff  <= 1'b1;
               end else if (mul_done) begin
                  issued_ff <= 1'b0;
                  sum_ff    <= sum_ff + mul_res;
                  if (cnt_ff == 3'd2) begin
                     state_ff <= S_SQRT;
                  end else begin
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end
            end
            S_SQRT: begin
               if (!issued_ff) begin
                  sd_cmd_ff <= '{start: 1'b1, is_sqrt: 1'b1};
                  issued_ff <= 1'b1;
               end else if (sd_done) begin
                  issued_ff <= 1'b0;
                  range_ff  <= (sd_res[SD_RES_W-1:RNG_W] != '0) ? {RNG_W{1'b1}}
                                                                : sd_res[RNG_W-1:0];
                  state_ff  <= last_pass_ff ? S_DONE : S_DIV;
               end
            end
            S_DIV: begin
               if (!issued_ff) begin
                  sd_cmd_ff <= '{start: 1'b1, is_sqrt: 1'b0};
                  issued_ff <= 1'b1;
               end else if (sd_done) begin
                  issued_ff  <= 1'b0;
                  tof_new_ff <= sd_res[TOF_W-1:0];
                  state_ff   <= S_CHECK;
               end
            end
            S_CHECK: begin
               tof_ff <= tof_new_ff;
               if (delta <= thr_ff || ({1'b0, iter_ff} + 5'd1) >= {1'b0, max_iter_ff}) begin
                  last_pass_ff <= 1'b1;
               end else begin
                  iter_ff <= iter_ff + 4'd1;
               end
               state_ff <= S_ANG;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  out_range_ff <= range_ff;
                  out_x_ff     <= rp_x_ff;
                  out_y_ff     <= rp_y_ff;
                  out_z_ff     <= sp_ff[2];
                  out_vx_ff    <= rv_x_ff;
                  out_vy_ff    <= rv_y_ff;
                  out_vz_ff    <= sv_ff[2];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/srs_checker.sv]
module srs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [srs_pkg::RNG_W-1:0]   rsp_geo_range,
   input logic [srs_pkg::POS_W-1:0]   rsp_rot_x
);
   import srs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_geo_range) && $stable(rsp_rot_x))
      else $error("stalled result word changed");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while an item is in progress");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared right after an item was taken");

endmodule

bind sagnac_range_solver srs_checker u_srs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_geo_range (rsp_chan.geo_range),
   .rsp_rot_x     (rsp_chan.rot_x)
);
